@@ design/wbmp_pkg.sv @@
// Shared types and constants for the weighted book move picker.
// No dependencies.
package wbmp_pkg;

  localparam int MAX_KEYS_DEF       = 256;
  localparam int MAX_CANDIDATES_DEF = 16;
  localparam int VERTEX_BITS_DEF    = 10;
  localparam int WEIGHT_W           = 14;
  localparam int KEY_W              = 64;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_ADD   = 2'd2,
    FUNC_PROBE = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [KEY_W-1:0]    position_key;
    logic                eligible;
    logic [9:0]          cand_vertex;
    logic [WEIGHT_W-1:0] cand_weight;
    logic [KEY_W-1:0]    random_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0] move_vertex;
    logic       no_move;
    logic       dropped;
  } out_item_t;

endpackage

@@ design/wbmp_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module wbmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/wbmp_fifo.sv @@
// Two-entry queue between the front and back parts.
// Depends on wbmp_pkg.
module wbmp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  wbmp_pkg::in_item_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output wbmp_pkg::in_item_t rd_data,
  output logic               empty
);
  wbmp_pkg::in_item_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = slot_r[rp_r];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wp_r] <= wr_data;
  end
endmodule

@@ design/wbmp_mod.sv @@
// Iterative 64-bit by 32-bit modulo unit, one quotient bit per cycle.
// No dependencies.
module wbmp_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [63:0] num_r;
  logic [31:0] rem_r;
  logic [31:0] div_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] shifted;
  logic [33:0] diff;

  assign shifted   = {rem_r, num_r[63]};
  assign diff      = {1'b0, shifted} - {2'b00, div_r};
  assign remainder = rem_r;

  // shift and subtract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor, so 32 bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[62:0], 1'b0};
      rem_r <= diff[33] ? shifted[31:0] : diff[31:0];
    end
  end
endmodule

@@ design/wbmp_back.sv @@
// Back part: table storage, key search, candidate sort and weighted draw.
// Depends on wbmp_pkg, wbmp_ram and wbmp_mod.
module wbmp_back #(
  parameter int MAX_KEYS       = wbmp_pkg::MAX_KEYS_DEF,
  parameter int MAX_CANDIDATES = wbmp_pkg::MAX_CANDIDATES_DEF,
  parameter int VERTEX_BITS    = wbmp_pkg::VERTEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  wbmp_pkg::in_item_t  cmd,
  output logic                cmd_take,
  output logic                res_valid,
  output wbmp_pkg::out_item_t res,
  input  logic                res_stall
);
  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int NW = $clog2(MAX_CANDIDATES + 1);
  localparam int TW = KW + 1;
  localparam int SW = KW + CW;
  localparam int WW = wbmp_pkg::WEIGHT_W;
  localparam int SUMW = WW + NW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SRCH  = 9'b000000010,
    ST_SCMP  = 9'b000000100,
    ST_CNT   = 9'b000001000,
    ST_LOAD  = 9'b000010000,
    ST_LWAIT = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_PICK  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  wbmp_pkg::in_item_t cur_r;
  logic [MAX_KEYS-1:0] key_valid_r;
  logic [TW-1:0] key_total_r;
  logic [KW-1:0] cur_line_r;
  logic          discard_r;
  logic [TW-1:0] idx_r;
  logic          found_r;
  logic [KW-1:0] hit_r;
  logic [NW-1:0] n_r, ld_r;
  logic [VERTEX_BITS-1:0] vv_r [MAX_CANDIDATES];
  logic [WW-1:0]          wv_r [MAX_CANDIDATES];
  logic [MAX_CANDIDATES-1:0] fill_r;
  logic [SUMW-1:0] total_r, acc_r;
  logic [NW-1:0]   pick_r;
  logic [31:0]     draw_r;
  wbmp_pkg::out_item_t res_r;
  wbmp_pkg::out_item_t out_r;
  logic res_valid_r;

  // key RAM
  logic             key_we;
  logic [KW-1:0]    key_addr;
  logic [63:0]      key_rd;
  wbmp_ram #(.WIDTH(64), .DEPTH(1 << KW)) u_key (
    .clk(clk), .we(key_we), .addr(key_addr), .wdata(cur_r.position_key), .rdata(key_rd)
  );

  // candidate count RAM
  logic          cnt_we;
  logic [KW-1:0] cnt_addr;
  logic [NW-1:0] cnt_wdata, cnt_rd;
  wbmp_ram #(.WIDTH(NW), .DEPTH(1 << KW)) u_cnt (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rd)
  );

  // candidate slot RAM, vertex and weight side by side
  logic          slot_we;
  logic [SW-1:0] slot_addr;
  logic [VERTEX_BITS+WW-1:0] slot_rd;
  wbmp_ram #(.WIDTH(VERTEX_BITS + WW), .DEPTH(1 << SW)) u_slot (
    .clk(clk), .we(slot_we), .addr(slot_addr),
    .wdata({cur_r.cand_vertex[VERTEX_BITS-1:0], cur_r.cand_weight}), .rdata(slot_rd)
  );

  // modulo unit
  logic        mod_start, mod_done;
  logic [31:0] mod_rem;
  wbmp_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(cur_r.random_value),
    .divisor(32'(total_r)), .done(mod_done), .remainder(mod_rem)
  );

  logic cnt_full;
  assign cnt_full = (cnt_rd >= NW'(MAX_CANDIDATES));

  assign cmd_take  = (state_r == ST_IDLE) && cmd_valid;
  assign res_valid = res_valid_r;
  assign res       = out_r;

  // memory control, modulo start and next state
  always_comb begin
    key_we    = 1'b0;
    key_addr  = idx_r[KW-1:0];
    cnt_we    = 1'b0;
    cnt_addr  = cur_line_r;
    cnt_wdata = '0;
    slot_we   = 1'b0;
    slot_addr = {cur_line_r, cnt_rd[CW-1:0]};
    mod_start = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd_take) state_nxt = ST_SRCH;
      ST_SRCH: begin
        if (cur_r.func == wbmp_pkg::FUNC_CLEAR) begin
          state_nxt = ST_OUT;
        end else if (cur_r.func == wbmp_pkg::FUNC_ADD) begin
          state_nxt = discard_r ? ST_OUT : ST_CNT;
        end else if (cur_r.func == wbmp_pkg::FUNC_PROBE && !cur_r.eligible) begin
          state_nxt = ST_OUT;
        end else if (idx_r >= key_total_r) begin
          if (cur_r.func == wbmp_pkg::FUNC_BEGIN) begin
            if (!found_r && key_total_r < TW'(MAX_KEYS)) begin
              key_we    = 1'b1;
              key_addr  = key_total_r[KW-1:0];
              cnt_we    = 1'b1;
              cnt_addr  = key_total_r[KW-1:0];
            end
            state_nxt = ST_OUT;
          end else begin
            cnt_addr  = hit_r;
            state_nxt = found_r ? ST_CNT : ST_OUT;
          end
        end else begin
          // a hit jumps the index to the end, so here the search goes on
          state_nxt = ST_SCMP;
        end
      end
      ST_SCMP: state_nxt = ST_SRCH;
      ST_CNT: begin
        if (cur_r.func == wbmp_pkg::FUNC_ADD) begin
          if (!cnt_full) begin
            slot_we   = 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd + NW'(1);
          end
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        slot_addr = {hit_r, ld_r[CW-1:0]};
        state_nxt = (ld_r >= n_r) ? ST_LWAIT : ST_LOAD;
      end
      ST_LWAIT: begin
        if (total_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          mod_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: if (mod_done) state_nxt = ST_PICK;
      ST_PICK: if (pick_r >= n_r || draw_r < 32'(acc_r) + 32'(wv_r[pick_r[CW-1:0]]))
        state_nxt = ST_OUT;
      ST_OUT: if (!res_valid_r || !res_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_valid_r <= '0;
      key_total_r <= '0;
      cur_line_r  <= '0;
      discard_r   <= 1'b1;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // raise on a new result, drop once the held beat is taken
      if (state_r == ST_OUT && state_nxt == ST_IDLE) res_valid_r <= 1'b1;
      else if (!res_stall) res_valid_r <= 1'b0;
      if (state_r == ST_SRCH) begin
        if (cur_r.func == wbmp_pkg::FUNC_CLEAR) begin
          key_valid_r <= '0;
          key_total_r <= '0;
          cur_line_r  <= '0;
          discard_r   <= 1'b1;
        end else if (cur_r.func == wbmp_pkg::FUNC_BEGIN && idx_r >= key_total_r) begin
          if (!found_r && key_total_r < TW'(MAX_KEYS)) begin
            cur_line_r  <= key_total_r[KW-1:0];
            key_valid_r[key_total_r[KW-1:0]] <= 1'b1;
            key_total_r <= key_total_r + TW'(1);
            discard_r   <= 1'b0;
          end else begin
            discard_r <= 1'b1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_r   <= cmd;
      idx_r   <= '0;
      found_r <= 1'b0;
      res_r   <= '{move_vertex: '0, no_move: (cmd.func == wbmp_pkg::FUNC_PROBE),
                   dropped: 1'b0};
    end
    // hold the finished result in the output register
    if (state_r == ST_OUT && state_nxt == ST_IDLE) out_r <= res_r;
    // compare one stored key per pass through the search and compare states
    if (state_r == ST_SCMP) begin
      if (key_valid_r[idx_r[KW-1:0]] && key_rd == cur_r.position_key) begin
        found_r <= 1'b1;
        hit_r   <= idx_r[KW-1:0];
        idx_r   <= key_total_r;
      end else begin
        idx_r <= idx_r + TW'(1);
      end
    end
    if (state_r == ST_SRCH && cur_r.func == wbmp_pkg::FUNC_BEGIN && idx_r >= key_total_r
        && !found_r && key_total_r >= TW'(MAX_KEYS)) begin
      res_r.dropped <= 1'b1;
    end
    if (state_r == ST_CNT) begin
      if (cur_r.func == wbmp_pkg::FUNC_ADD) begin
        if (cnt_full) res_r.dropped <= 1'b1;
      end else begin
        n_r     <= cnt_full ? NW'(MAX_CANDIDATES) : cnt_rd;
        ld_r    <= '0;
        fill_r  <= '0;
        total_r <= '0;
      end
    end
    // insertion sort: one candidate enters per cycle
    if (state_r == ST_LOAD || state_r == ST_LWAIT) begin
      if (ld_r != '0 && ld_r <= n_r) begin
        for (int i = 0; i < MAX_CANDIDATES; i++) begin
          if (fill_r[i]) begin
            if (wv_r[i] < slot_rd[WW-1:0] ||
                (wv_r[i] == slot_rd[WW-1:0] && vv_r[i] < slot_rd[VERTEX_BITS+WW-1:WW])) begin
              if (i + 1 < MAX_CANDIDATES) begin
                wv_r[(i + 1) % MAX_CANDIDATES] <= wv_r[i];
                vv_r[(i + 1) % MAX_CANDIDATES] <= vv_r[i];
              end
              if (i == 0 || !(wv_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES]
                  < slot_rd[WW-1:0] || (wv_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES]
                  == slot_rd[WW-1:0] && vv_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES]
                  < slot_rd[VERTEX_BITS+WW-1:WW]))) begin
                wv_r[i] <= slot_rd[WW-1:0];
                vv_r[i] <= slot_rd[VERTEX_BITS+WW-1:WW];
              end
            end
          end else if (i == 0 || (fill_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES] &&
              !(wv_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES] < slot_rd[WW-1:0] ||
              (wv_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES] == slot_rd[WW-1:0] &&
              vv_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES]
              < slot_rd[VERTEX_BITS+WW-1:WW])))) begin
            if (i == 0 || fill_r[(i + MAX_CANDIDATES - 1) % MAX_CANDIDATES]) begin
              wv_r[i] <= slot_rd[WW-1:0];
              vv_r[i] <= slot_rd[VERTEX_BITS+WW-1:WW];
            end
          end
        end
        fill_r  <= {fill_r[MAX_CANDIDATES-2 >= 0 ? MAX_CANDIDATES-2 : 0:0], 1'b1};
        total_r <= total_r + SUMW'(slot_rd[WW-1:0]);
      end
      if (state_r == ST_LOAD) ld_r <= ld_r + NW'(1);
    end
    if (mod_done) begin
      draw_r <= mod_rem;
      acc_r  <= '0;
      pick_r <= '0;
    end
    // walk the running sum, one candidate per cycle
    if (state_r == ST_PICK && pick_r < n_r) begin
      if (draw_r < 32'(acc_r) + 32'(wv_r[pick_r[CW-1:0]])) begin
        res_r <= '{move_vertex: 10'(vv_r[pick_r[CW-1:0]]), no_move: 1'b0, dropped: 1'b0};
      end
      acc_r  <= acc_r + SUMW'(wv_r[pick_r[CW-1:0]]);
      pick_r <= pick_r + NW'(1);
    end
  end
endmodule

@@ design/weighted_book_move_picker.sv @@
// Weighted opening-book move picker: keyed table of weighted candidates.
// Operation: clear empties the table, add stores a candidate on the current line, begin/probe search
// the stored keys in turn; a probe then sorts the candidates, takes the draw modulo the total weight and picks.
// Throughput: one item at a time in the back part; a two-entry queue decouples input.
// Reset: synchronous active-low rst_n empties the table; stored keys and slots are not cleared.
module weighted_book_move_picker #(
  parameter int MAX_KEYS       = wbmp_pkg::MAX_KEYS_DEF,
  parameter int MAX_CANDIDATES = wbmp_pkg::MAX_CANDIDATES_DEF,
  parameter int VERTEX_BITS    = wbmp_pkg::VERTEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wbmp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wbmp_pkg::out_item_t out_data
);
  logic fifo_full, fifo_empty, take;
  wbmp_pkg::in_item_t q_data;

  assign in_stall = fifo_full;

  // front: queue accepted beats
  wbmp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(in_valid && !fifo_full), .wr_data(in_data),
    .full(fifo_full), .rd_en(take), .rd_data(q_data), .empty(fifo_empty)
  );

  wbmp_back #(
    .MAX_KEYS(MAX_KEYS), .MAX_CANDIDATES(MAX_CANDIDATES), .VERTEX_BITS(VERTEX_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!fifo_empty),
    .cmd(q_data), .cmd_take(take), .res_valid(out_valid), .res(out_data),
    .res_stall(out_stall)
  );

`ifndef SYNTHESIS
  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result changed");
  // never take from an empty queue
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !fifo_empty) else $error("take from empty queue");
  // no_move and dropped never come together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.no_move && out_data.dropped)) else $error("both flags set");
`endif
endmodule
